// ----- rtl/ljc_pkg.sv -----
// Shared constants and types for the pair kernel pipeline.
`timescale 1ns / 1ps
package ljc_pkg;

  localparam int R2_W       = 32;
  localparam int COEF_W     = 48;
  localparam int Q_W        = 32;
  localparam int WORD_W     = 64;
  localparam int HALF_W     = WORD_W / 2;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int RAD_SHIFT  = 24;

  localparam int SQRT_STEPS = 28;
  localparam int SQ_RAD_W   = 2 * SQRT_STEPS;
  localparam int SQ_ROOT_W  = SQRT_STEPS;
  localparam int SQ_REM_W   = SQRT_STEPS + 2;

  localparam int DIV_STEPS  = 57;
  localparam int DIV_Q_W    = DIV_STEPS;
  localparam int DIV_D_W    = 32;

  typedef enum logic [1:0] {
    SH_0,
    SH_16,
    SH_32
  } shift_t;

  typedef struct packed {
    logic [SQ_RAD_W-1:0]  rad;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DIV_D_W-1:0] rem;
    logic [DIV_Q_W-1:0] quo;
    logic [DIV_D_W-1:0] den;
  } dv_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    shift_t            sh;
  } mul_op_t;

endpackage

// ----- rtl/ljc_sqrt_cell.sv -----
// One digit step of the integer square root chain.
`timescale 1ns / 1ps
module ljc_sqrt_cell (
  input  logic         clk,
  input  logic         en,
  input  ljc_pkg::sq_t d,
  output ljc_pkg::sq_t q
);
  import ljc_pkg::*;

  logic [SQ_REM_W+1:0] rem_sh;
  logic [SQ_REM_W+1:0] trial;
  sq_t                 q_next;

  always_comb begin
    rem_sh     = {d.rem, d.rad[SQ_RAD_W-1 -: 2]};
    trial      = {2'b00, d.root, 2'b01};
    q_next.rad = {d.rad[SQ_RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      q_next.rem  = SQ_REM_W'(rem_sh - trial);
      q_next.root = {d.root[SQ_ROOT_W-2:0], 1'b1};
    end else begin
      q_next.rem  = rem_sh[SQ_REM_W-1:0];
      q_next.root = {d.root[SQ_ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ----- rtl/ljc_div_cell.sv -----
// One quotient bit of the restoring divider chain.
`timescale 1ns / 1ps
module ljc_div_cell (
  input  logic         clk,
  input  logic         en,
  input  logic         bit_in,
  input  ljc_pkg::dv_t d,
  output ljc_pkg::dv_t q
);
  import ljc_pkg::*;

  logic [DIV_D_W:0] rem_sh;
  dv_t              q_next;

  always_comb begin
    rem_sh     = {d.rem, bit_in};
    q_next.den = d.den;
    if (rem_sh >= {1'b0, d.den}) begin
      q_next.rem = DIV_D_W'(rem_sh - {1'b0, d.den});
      q_next.quo = {d.quo[DIV_Q_W-2:0], 1'b1};
    end else begin
      q_next.rem = rem_sh[DIV_D_W-1:0];
      q_next.quo = {d.quo[DIV_Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ----- rtl/ljc_mul.sv -----
// Three-stage 64x64 multiplier from 32x32 partial products, shift and saturate.
`timescale 1ns / 1ps
module ljc_mul (
  input  logic               clk,
  input  logic               en,
  input  ljc_pkg::mul_op_t   op,
  output logic [63:0]        res,
  output logic               sat
);
  import ljc_pkg::*;

  logic [WORD_W-1:0] pp_ll;
  logic [WORD_W-1:0] pp_lh;
  logic [WORD_W-1:0] pp_hl;
  logic [WORD_W-1:0] pp_hh;
  shift_t            sh1;
  shift_t            sh2;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_sh;

  always_comb begin
    unique case (sh2)
      SH_0:    prod_sh = prod;
      SH_16:   prod_sh = prod >> 16;
      SH_32:   prod_sh = prod >> 32;
      default: prod_sh = prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= {{HALF_W{1'b0}}, op.a[HALF_W-1:0]} * {{HALF_W{1'b0}}, op.b[HALF_W-1:0]};
      pp_lh <= {{HALF_W{1'b0}}, op.a[HALF_W-1:0]} * {{HALF_W{1'b0}}, op.b[WORD_W-1:HALF_W]};
      pp_hl <= {{HALF_W{1'b0}}, op.a[WORD_W-1:HALF_W]} * {{HALF_W{1'b0}}, op.b[HALF_W-1:0]};
      pp_hh <= {{HALF_W{1'b0}}, op.a[WORD_W-1:HALF_W]} * {{HALF_W{1'b0}}, op.b[WORD_W-1:HALF_W]};
      sh1   <= op.sh;
      prod  <= {pp_hh, pp_ll}
             + {{HALF_W{1'b0}}, pp_lh, {HALF_W{1'b0}}}
             + {{HALF_W{1'b0}}, pp_hl, {HALF_W{1'b0}}};
      sh2   <= sh1;
      sat   <= |prod_sh[PROD_W-1:WORD_W];
      res   <= (|prod_sh[PROD_W-1:WORD_W]) ? {WORD_W{1'b1}} : prod_sh[WORD_W-1:0];
    end
  end

endmodule

// ----- rtl/lj_coulomb_pair_kernel_unit.sv -----
// Top level of the Lennard-Jones 12-6 plus Coulomb pair kernel pipeline.
// Path from an input transfer to the result on m_tvalid: 28 square root cells,
// 57 divider cells (1/r2 and 1/r side by side), six multiply levels, one sum stage
// and the output register.
// Throughput: one pair per cycle; the whole pipeline holds while a result waits.
// Reset: rst clears every stage valid bit and m_tvalid; data registers are not reset.
`timescale 1ns / 1ps
module lj_coulomb_pair_kernel_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // squared_distance[31:0], coef_a[79:32], coef_b[127:80], coef_q[159:128]
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // energy_term[63:0], force_factor[127:64]
  output logic [127:0] m_tdata,
  // overflow[0]
  output logic [0:0]   m_tuser
);
  import ljc_pkg::*;

  localparam int CHAIN_DEPTH = SQRT_STEPS + DIV_STEPS;
  localparam int NUM_LEVELS  = 6;
  localparam int MUL_STAGES  = 3;

  // multiply levels, in pipeline order
  localparam int LV_IR2   = 0;
  localparam int LV_IR3   = 1;
  localparam int LV_IR6   = 2;
  localparam int LV_LJ    = 3;
  localparam int LV_SCALE = 4;
  localparam int LV_FORCE = 5;

  localparam logic [WORD_W-1:0] SIX_Q16 = WORD_W'(6) << 16;
  localparam logic [WORD_W-1:0] POS_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] NEG_MAX = {1'b1, {(WORD_W-1){1'b0}}};

  // payload that rides beside the root and divider cells
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [R2_W-1:0]   r2;
    logic [COEF_W-1:0] ca;
    logic [COEF_W-1:0] cb;
    logic              qneg;
    logic [Q_W-1:0]    qmag;
  } chain_t;

  // payload through the multiply levels; magnitudes with separate signs
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic              csat;
    logic              sat;
    logic [COEF_W-1:0] ca;
    logic [COEF_W-1:0] cb;
    logic              qneg;
    logic [Q_W-1:0]    qmag;
    logic [WORD_W-1:0] ir;
    logic [WORD_W-1:0] irr;
    logic [WORD_W-1:0] ir2;
    logic [WORD_W-1:0] ir3;
    logic [WORD_W-1:0] ir6;
    logic [WORD_W-1:0] ecm;
    logic [WORD_W-1:0] f6;
    logic              t_neg;
    logic [WORD_W-1:0] t_mag;
    logic              t2_neg;
    logic [WORD_W-1:0] t2_mag;
    logic [WORD_W-1:0] e1;
    logic [WORD_W-1:0] t3;
    logic [WORD_W-1:0] t4;
    logic [WORD_W-1:0] fm;
  } post_t;

  typedef struct packed {
    mul_op_t m0;
    mul_op_t m1;
  } lvl_ops_t;

  typedef struct packed {
    logic              neg;
    logic [WORD_W-1:0] mag;
    logic              sat;
  } sum_t;

  typedef struct packed {
    logic [WORD_W-1:0] val;
    logic              sat;
  } pack_t;

  typedef struct packed {
    logic              valid;
    logic              zero;
    logic              sat;
    logic              e_neg;
    logic [WORD_W-1:0] e_mag;
    logic              f_neg;
    logic [WORD_W-1:0] f_mag;
  } fin_t;

  // signed-magnitude add; a result magnitude above 2^64-1 saturates
  function automatic sum_t sm_add(logic a_neg, logic [WORD_W-1:0] a_mag,
                                  logic b_neg, logic [WORD_W-1:0] b_mag);
    sum_t          r;
    logic [WORD_W:0] s;
    r = '0;
    if (a_neg == b_neg) begin
      s = {1'b0, a_mag} + {1'b0, b_mag};
      r.sat = s[WORD_W];
      r.mag = s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
      r.neg = a_neg && (r.mag != '0);
    end else if (a_mag >= b_mag) begin
      r.mag = a_mag - b_mag;
      r.neg = a_neg && (r.mag != '0);
    end else begin
      r.mag = b_mag - a_mag;
      r.neg = b_neg;
    end
    return r;
  endfunction

  // clamp a signed magnitude into the two's complement 64-bit range
  function automatic pack_t sm_pack(logic neg, logic [WORD_W-1:0] mag);
    pack_t r;
    r = '0;
    if (neg) begin
      if (mag > NEG_MAX) begin
        r.val = NEG_MAX;
        r.sat = 1'b1;
      end else begin
        r.val = ~mag + WORD_W'(1);
      end
    end else if (mag > POS_MAX) begin
      r.val = POS_MAX;
      r.sat = 1'b1;
    end else begin
      r.val = mag;
    end
    return r;
  endfunction

  // operand selection for the two multipliers of each level
  function automatic lvl_ops_t level_ops(int level, post_t p);
    lvl_ops_t          o;
    logic [WORD_W-1:0] ca_w;
    logic [WORD_W-1:0] ca12;
    ca_w = {{(WORD_W-COEF_W){1'b0}}, p.ca};
    ca12 = (ca_w << 3) + (ca_w << 2);
    o = '0;
    unique case (level)
      LV_IR2: begin
        o.m0 = '{a: p.ir, b: p.ir, sh: SH_32};
        o.m1 = '{a: {{(WORD_W-Q_W){1'b0}}, p.qmag}, b: p.irr, sh: SH_16};
      end
      LV_IR3: begin
        o.m0 = '{a: p.ir2, b: p.ir, sh: SH_32};
        o.m1 = '{a: {{(WORD_W-COEF_W){1'b0}}, p.cb}, b: SIX_Q16, sh: SH_0};
      end
      LV_IR6: begin
        o.m0 = '{a: p.ir3, b: p.ir3, sh: SH_32};
        o.m1 = '{a: '0, b: '0, sh: SH_0};
      end
      LV_LJ: begin
        o.m0 = '{a: ca_w, b: p.ir6, sh: SH_16};
        o.m1 = '{a: ca12, b: p.ir6, sh: SH_16};
      end
      LV_SCALE: begin
        o.m0 = '{a: p.t_mag, b: p.ir6, sh: SH_32};
        o.m1 = '{a: p.t2_mag, b: p.ir6, sh: SH_32};
      end
      LV_FORCE: begin
        o.m0 = '{a: p.t3, b: p.ir, sh: SH_32};
        o.m1 = '{a: p.ecm, b: p.ir, sh: SH_32};
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  // fold the multiplier results of a level back into the payload
  function automatic post_t level_merge(int level, post_t p, logic [WORD_W-1:0] r0,
                                        logic s0, logic [WORD_W-1:0] r1, logic s1);
    post_t             n;
    logic [WORD_W-1:0] b16;
    n   = p;
    b16 = {p.cb, 16'b0};
    unique case (level)
      LV_IR2: begin
        n.ir2  = r0;
        n.csat = p.csat | s0;
        n.ecm  = r1;
        n.sat  = p.sat | s1;
      end
      LV_IR3: begin
        n.ir3  = r0;
        n.csat = p.csat | s0;
        n.f6   = r1;
        n.sat  = p.sat | s1;
      end
      LV_IR6: begin
        // the inverse power chain only flags when A or B uses it
        n.ir6  = r0;
        n.csat = p.csat | s0;
        n.sat  = p.sat | ((p.csat | s0) && ((p.ca | p.cb) != '0));
      end
      LV_LJ: begin
        n.sat = p.sat | s0 | s1;
        if (r0 >= b16) begin
          n.t_neg = 1'b0;
          n.t_mag = r0 - b16;
        end else begin
          n.t_neg = 1'b1;
          n.t_mag = b16 - r0;
        end
        if (p.f6 >= r1) begin
          n.t2_neg = 1'b0;
          n.t2_mag = p.f6 - r1;
        end else begin
          n.t2_neg = 1'b1;
          n.t2_mag = r1 - p.f6;
        end
      end
      LV_SCALE: begin
        n.e1  = r0;
        n.t3  = r1;
        n.sat = p.sat | s0 | s1;
      end
      LV_FORCE: begin
        n.t4  = r0;
        n.fm  = r1;
        n.sat = p.sat | s0 | s1;
      end
      default: n = p;
    endcase
    return n;
  endfunction

  logic              en;
  chain_t            pay_in;
  chain_t            pay [CHAIN_DEPTH];
  sq_t               sq_init;
  sq_t               sq_q [SQRT_STEPS];
  dv_t               ir_init;
  dv_t               irr_init;
  dv_t               ir_q [DIV_STEPS];
  dv_t               irr_q [DIV_STEPS];
  post_t             lv_in;
  post_t             lv_reg [NUM_LEVELS+1];
  post_t             lv_next [NUM_LEVELS];
  post_t             dly [NUM_LEVELS][MUL_STAGES];
  lvl_ops_t          lv_ops [NUM_LEVELS];
  logic [WORD_W-1:0] res0 [NUM_LEVELS];
  logic [WORD_W-1:0] res1 [NUM_LEVELS];
  logic              sat0 [NUM_LEVELS];
  logic              sat1 [NUM_LEVELS];
  fin_t              fin;
  fin_t              fin_next;
  sum_t              e_sum;
  sum_t              f_sum;
  pack_t             e_pk;
  pack_t             f_pk;
  logic [127:0]      out_data;
  logic              out_flag;

  // hold every stage while a finished result waits; take nothing during reset
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  always_comb begin
    pay_in.valid = s_tvalid;
    pay_in.r2    = s_tdata[31:0];
    pay_in.ca    = s_tdata[79:32];
    pay_in.cb    = s_tdata[127:80];
    pay_in.qneg  = s_tdata[159];
    pay_in.qmag  = s_tdata[159] ? (~s_tdata[159:128] + Q_W'(1)) : s_tdata[159:128];
    pay_in.zero  = (s_tdata[31:0] == '0);
    sq_init.rad  = {s_tdata[31:0], {RAD_SHIFT{1'b0}}};
    sq_init.rem  = '0;
    sq_init.root = '0;
  end

  // r = sqrt(r2 << 24), one root bit per cell
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      ljc_sqrt_cell u_cell (.clk(clk), .en(en), .d(sq_init), .q(sq_q[k]));
    end else begin : g_next
      ljc_sqrt_cell u_cell (.clk(clk), .en(en), .d(sq_q[k-1]), .q(sq_q[k]));
    end
  end

  always_comb begin
    ir_init.rem  = '0;
    ir_init.quo  = '0;
    ir_init.den  = pay[SQRT_STEPS-1].r2;
    irr_init.rem = '0;
    irr_init.quo = '0;
    irr_init.den = {{(DIV_D_W-SQ_ROOT_W){1'b0}}, sq_q[SQRT_STEPS-1].root};
  end

  // 2^56 / r2 and 2^56 / r side by side, one quotient bit per cell
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    if (j == 0) begin : g_first
      ljc_div_cell u_ir  (.clk(clk), .en(en), .bit_in(1'b1), .d(ir_init),  .q(ir_q[j]));
      ljc_div_cell u_irr (.clk(clk), .en(en), .bit_in(1'b1), .d(irr_init), .q(irr_q[j]));
    end else begin : g_next
      ljc_div_cell u_ir  (.clk(clk), .en(en), .bit_in(1'b0), .d(ir_q[j-1]),  .q(ir_q[j]));
      ljc_div_cell u_irr (.clk(clk), .en(en), .bit_in(1'b0), .d(irr_q[j-1]), .q(irr_q[j]));
    end
  end

  always_comb begin
    lv_in       = '0;
    lv_in.valid = pay[CHAIN_DEPTH-1].valid;
    lv_in.zero  = pay[CHAIN_DEPTH-1].zero;
    lv_in.ca    = pay[CHAIN_DEPTH-1].ca;
    lv_in.cb    = pay[CHAIN_DEPTH-1].cb;
    lv_in.qneg  = pay[CHAIN_DEPTH-1].qneg;
    lv_in.qmag  = pay[CHAIN_DEPTH-1].qmag;
    lv_in.ir    = {{(WORD_W-DIV_Q_W){1'b0}}, ir_q[DIV_STEPS-1].quo};
    lv_in.irr   = {{(WORD_W-DIV_Q_W){1'b0}}, irr_q[DIV_STEPS-1].quo};
  end

  // multiply levels: operands from lv_reg, results meet the payload copy carried through dly
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
    assign lv_ops[g] = level_ops(g, lv_reg[g]);

    ljc_mul u_mul0 (.clk(clk), .en(en), .op(lv_ops[g].m0), .res(res0[g]), .sat(sat0[g]));
    ljc_mul u_mul1 (.clk(clk), .en(en), .op(lv_ops[g].m1), .res(res1[g]), .sat(sat1[g]));

    assign lv_next[g] = level_merge(g, dly[g][MUL_STAGES-1], res0[g], sat0[g],
                                    res1[g], sat1[g]);
  end

  // final sums: V = e1 + q/r, force = t4 - (q/r)/r2
  always_comb begin
    e_sum = sm_add(lv_reg[NUM_LEVELS].t_neg && (lv_reg[NUM_LEVELS].e1 != '0),
                   lv_reg[NUM_LEVELS].e1,
                   lv_reg[NUM_LEVELS].qneg && (lv_reg[NUM_LEVELS].ecm != '0),
                   lv_reg[NUM_LEVELS].ecm);
    f_sum = sm_add(lv_reg[NUM_LEVELS].t2_neg && (lv_reg[NUM_LEVELS].t4 != '0),
                   lv_reg[NUM_LEVELS].t4,
                   (lv_reg[NUM_LEVELS].fm != '0) && !lv_reg[NUM_LEVELS].qneg,
                   lv_reg[NUM_LEVELS].fm);
    fin_next.valid = lv_reg[NUM_LEVELS].valid;
    fin_next.zero  = lv_reg[NUM_LEVELS].zero;
    fin_next.sat   = lv_reg[NUM_LEVELS].sat | e_sum.sat | f_sum.sat;
    fin_next.e_neg = e_sum.neg;
    fin_next.e_mag = e_sum.mag;
    fin_next.f_neg = f_sum.neg;
    fin_next.f_mag = f_sum.mag;
  end

  // clamp to the output range; a zero distance drops both results and flags
  always_comb begin
    e_pk = sm_pack(fin.e_neg, fin.e_mag);
    f_pk = sm_pack(fin.f_neg, fin.f_mag);
    if (fin.zero) begin
      out_data = '0;
      out_flag = 1'b1;
    end else begin
      out_data = {f_pk.val, e_pk.val};
      out_flag = fin.sat | e_pk.sat | f_pk.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHAIN_DEPTH; k++) begin
        pay[k].valid <= 1'b0;
      end
      for (int g = 0; g <= NUM_LEVELS; g++) begin
        lv_reg[g].valid <= 1'b0;
      end
      for (int g = 0; g < NUM_LEVELS; g++) begin
        for (int s = 0; s < MUL_STAGES; s++) begin
          dly[g][s].valid <= 1'b0;
        end
      end
      fin.valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else if (en) begin
      // advance the whole pipeline by one stage
      pay[0] <= pay_in;
      for (int k = 1; k < CHAIN_DEPTH; k++) begin
        pay[k] <= pay[k-1];
      end
      lv_reg[0] <= lv_in;
      for (int g = 0; g < NUM_LEVELS; g++) begin
        dly[g][0] <= lv_reg[g];
        for (int s = 1; s < MUL_STAGES; s++) begin
          dly[g][s] <= dly[g][s-1];
        end
        lv_reg[g+1] <= lv_next[g];
      end
      fin        <= fin_next;
      m_tvalid   <= fin.valid;
      m_tdata    <= out_data;
      m_tuser[0] <= out_flag;
    end
  end

endmodule
